/* hdl/psd_pkg.sv */
// Package for the point-to-segment distance block: widths and item types.
// No dependencies; used by hdl/point_segment_distance.sv.
package psd_pkg;

   localparam int COORD_BITS = 24;
   localparam int DIST_BITS  = COORD_BITS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 projects_inside;
   } rsp_type;

endpackage

/* hdl/point_segment_distance.sv */
// Point-to-segment distance, fully pipelined, one item per cycle.
// Depends on psd_pkg (widths, req_type, rsp_type).
//
//  channel | ports                            | payload
//  --------+----------------------------------+--------------------------
//  request | req_valid, req_ready, req_data   | segment ends, query point
//  result  | rsp_valid, rsp_ready, rsp_data   | distance, projects_inside
//
// One item enters per cycle unless the result stalls; the path runs through
// the front stages, the restoring divider (one quotient bit per stage),
// the square root (one root bit per stage) and the output register.
// Synchronous reset clears all valid bits only.
// A stalled result freezes the whole pipeline; nothing is lost or repeated.
module point_segment_distance
   import psd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;        // coordinate difference
   localparam int PW = 2 * CW + 2;    // signed product
   localparam int LW = 2 * CW + 1;    // squared length, |cross|
   localparam int NW = 4 * CW + 2;    // numerator
   localparam int QW = LW;            // quotient bits / divider stages
   localparam int KL = CW + 1;        // low split of |cross|
   localparam int KH = LW - KL;       // high split
   localparam int SQ = CW + 1;        // root bits / root stages
   localparam int RW = CW + 2;        // root remainder

   logic en;
   assign en        = rsp_ready | ~rsp_valid;
   assign req_ready = en;

   // stage 1: differences
   logic signed [DW-1:0] dx_ff, dy_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   logic                 v1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_valid;
      if (en) begin
         dx_ff <= DW'(req_data.end_x) - DW'(req_data.start_x);
         dy_ff <= DW'(req_data.end_y) - DW'(req_data.start_y);
         qx_ff <= DW'(req_data.query_x) - DW'(req_data.start_x);
         qy_ff <= DW'(req_data.query_y) - DW'(req_data.start_y);
         rx_ff <= DW'(req_data.query_x) - DW'(req_data.end_x);
         ry_ff <= DW'(req_data.query_y) - DW'(req_data.end_y);
      end
   end

   // stage 2: products
   logic signed [PW-1:0] pdd_x_ff, pdd_y_ff, pqq_x_ff, pqq_y_ff, prr_x_ff, prr_y_ff;
   logic signed [PW-1:0] pdot_x_ff, pdot_y_ff, pcr_a_ff, pcr_b_ff;
   logic                 v2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         pdd_x_ff  <= PW'(dx_ff * dx_ff);
         pdd_y_ff  <= PW'(dy_ff * dy_ff);
         pqq_x_ff  <= PW'(qx_ff * qx_ff);
         pqq_y_ff  <= PW'(qy_ff * qy_ff);
         prr_x_ff  <= PW'(rx_ff * rx_ff);
         prr_y_ff  <= PW'(ry_ff * ry_ff);
         pdot_x_ff <= PW'(dx_ff * qx_ff);
         pdot_y_ff <= PW'(dy_ff * qy_ff);
         pcr_a_ff  <= PW'(dx_ff * qy_ff);
         pcr_b_ff  <= PW'(dy_ff * qx_ff);
      end
   end

   // stage 3: sums, dot and |cross|
   logic signed [PW:0]   cross_in;
   logic [LW-1:0]        len2_ff, qq_ff, rr_ff, cabs_ff;
   logic signed [PW-1:0] dot_ff;
   logic                 v3_ff;
   assign cross_in = (PW+1)'(pcr_a_ff) - (PW+1)'(pcr_b_ff);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         len2_ff <= LW'(pdd_x_ff + pdd_y_ff);
         qq_ff   <= LW'(pqq_x_ff + pqq_y_ff);
         rr_ff   <= LW'(prr_x_ff + prr_y_ff);
         dot_ff  <= pdot_x_ff + pdot_y_ff;
         cabs_ff <= cross_in[PW] ? LW'(-cross_in) : LW'(cross_in);
      end
   end

   // stage 4: case selection and split square of |cross|
   logic           zero_len, on_seg;
   logic [KH-1:0]  c_hi;
   logic [KL-1:0]  c_lo;
   logic [2*KH-1:0]   hh_ff;
   logic [KH+KL-1:0]  hl_ff;
   logic [2*KL-1:0]   ll_ff;
   logic [LW-1:0]  base_ff, den4_ff;
   logic           use_cross_ff, inside4_ff, v4_ff;
   assign zero_len = (len2_ff == '0);
   assign on_seg   = ~dot_ff[PW-1] && (dot_ff <= $signed({1'b0, len2_ff}));
   assign c_hi     = cabs_ff[LW-1:KL];
   assign c_lo     = cabs_ff[KL-1:0];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
      if (en) begin
         hh_ff        <= c_hi * c_hi;
         hl_ff        <= c_hi * c_lo;
         ll_ff        <= c_lo * c_lo;
         use_cross_ff <= ~zero_len & on_seg;
         inside4_ff   <= zero_len | on_seg;
         den4_ff      <= len2_ff;
         base_ff      <= (zero_len || qq_ff <= rr_ff) ? qq_ff : rr_ff;
      end
   end

   // stage 5: numerator and divisor
   logic [NW-1:0] num_in;
   logic [NW-1:0] num_ff;
   logic [LW-1:0] den_ff;
   logic          inside5_ff, v5_ff;
   assign num_in = (NW'(hh_ff) << (2 * KL)) + (NW'(hl_ff) << (KL + 1)) + NW'(ll_ff);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (en) v5_ff <= v4_ff;
      if (en) begin
         num_ff     <= use_cross_ff ? num_in : NW'(base_ff);
         den_ff     <= use_cross_ff ? den4_ff : LW'(1);
         inside5_ff <= inside4_ff;
      end
   end

   // restoring divider: one quotient bit per stage; numerator bits shift out
   // of the top of the shift word while quotient bits enter at the bottom
   logic [LW-1:0] drem_ff [1:QW-1];
   logic [QW-1:0] dsh_ff  [1:QW];
   logic [LW-1:0] dden_ff [1:QW-1];
   logic          dins_ff [1:QW];
   logic          dv_ff   [1:QW];

   for (genvar g = 0; g < QW; g++) begin : g_div
      logic [LW-1:0] rem, den;
      logic [QW-1:0] sh;
      logic          ins, vld;
      logic [LW:0]   t;
      logic [LW-1:0] rem_in;
      logic [QW-1:0] sh_in;

      // stage inputs: the divider front takes the numerator and divisor
      if (g == 0) begin : g_first
         assign rem = num_ff[NW-1:QW];
         assign sh  = num_ff[QW-1:0];
         assign den = den_ff;
         assign ins = inside5_ff;
         assign vld = v5_ff;
      end else begin : g_next
         assign rem = drem_ff[g];
         assign sh  = dsh_ff[g];
         assign den = dden_ff[g];
         assign ins = dins_ff[g];
         assign vld = dv_ff[g];
      end

      // trial subtract
      assign t = {rem, sh[QW-1]};
      always_comb begin
         if (t >= {1'b0, den}) begin
            rem_in = LW'(t - {1'b0, den});
            sh_in  = {sh[QW-2:0], 1'b1};
         end else begin
            rem_in = t[LW-1:0];
            sh_in  = {sh[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[g+1] <= 1'b0;
         else if (en) dv_ff[g+1] <= vld;
         if (en) begin
            dsh_ff[g+1]  <= sh_in;
            dins_ff[g+1] <= ins;
         end
      end

      // remainder and divisor are not needed after the last stage
      if (g < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[g+1] <= rem_in;
               dden_ff[g+1] <= den;
            end
         end
      end
   end

   // digit-by-digit square root: one root bit per stage
   logic [RW-1:0]   srem_ff  [1:SQ-1];
   logic [SQ-1:0]   sroot_ff [1:SQ];
   logic [2*SQ-1:0] ssh_ff   [1:SQ-1];
   logic            sins_ff  [1:SQ];
   logic            sv_ff    [1:SQ];

   for (genvar g = 0; g < SQ; g++) begin : g_root
      logic [RW-1:0]   rem;
      logic [SQ-1:0]   root;
      logic [2*SQ-1:0] sh;
      logic            ins, vld;
      logic [RW+1:0]   t, trial;
      logic [RW-1:0]   rem_in;
      logic [SQ-1:0]   root_in;

      // stage inputs: the root front takes the quotient
      if (g == 0) begin : g_first
         assign rem  = '0;
         assign root = '0;
         assign sh   = {1'b0, dsh_ff[QW]};
         assign ins  = dins_ff[QW];
         assign vld  = dv_ff[QW];
      end else begin : g_next
         assign rem  = srem_ff[g];
         assign root = sroot_ff[g];
         assign sh   = ssh_ff[g];
         assign ins  = sins_ff[g];
         assign vld  = sv_ff[g];
      end

      // trial subtract of 4*root + 1
      assign t     = {rem, sh[2*SQ-1:2*SQ-2]};
      assign trial = (RW+2)'({root, 2'b01});
      always_comb begin
         if (t >= trial) begin
            rem_in  = RW'(t - trial);
            root_in = {root[SQ-2:0], 1'b1};
         end else begin
            rem_in  = RW'(t);
            root_in = {root[SQ-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sv_ff[g+1] <= 1'b0;
         else if (en) sv_ff[g+1] <= vld;
         if (en) begin
            sroot_ff[g+1] <= root_in;
            sins_ff[g+1]  <= ins;
         end
      end

      // remainder and radicand are not needed after the last stage
      if (g < SQ - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               srem_ff[g+1] <= rem_in;
               ssh_ff[g+1]  <= {sh[2*SQ-3:0], 2'b00};
            end
         end
      end
   end

   // output register
   logic    out_v_ff;
   rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= sv_ff[SQ];
      if (en) begin
         out_ff.distance        <= DIST_BITS'(sroot_ff[SQ]);
         out_ff.projects_inside <= sins_ff[SQ];
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // checks
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result stalled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   a_front_freeze: assert property (@(posedge clock) disable iff (reset)
      (!en && !$past(reset)) |=> ($stable(v5_ff) && $stable(num_ff)))
      else $error("pipeline moved during stall");

   a_end_point: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !inside4_ff) |-> !use_cross_ff)
      else $error("cross path used off the segment");

endmodule
